FILE: hdl/brf_pkg.sv
// Shared request codes, register indexes and sequencer state type for the byte ring FIFO.
package brf_pkg;

  // Request selector codes
  localparam logic [2:0] REQ_WRITE = 3'd0;
  localparam logic [2:0] REQ_READ  = 3'd1;
  localparam logic [2:0] REQ_PEEK  = 3'd2;
  localparam logic [2:0] REQ_DROP  = 3'd3;
  localparam logic [2:0] REQ_FIND  = 3'd4;
  localparam logic [2:0] REQ_CLEAR = 3'd5;

  // Configuration register indexes (taken from paddr[2])
  localparam logic REG_PATTERN = 1'b0;
  localparam logic REG_LEN     = 1'b1;

  // Largest header length the search logic handles
  localparam int HDR_LIMIT = 4;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_RESP = 4'b0010,
    ST_RDW  = 4'b0100,
    ST_FIND = 4'b1000
  } brf_state_t;

endpackage

FILE: hdl/byte_ring_fifo_peek_find.sv
// Byte ring FIFO with burst read, peek, drop, clear and frame-header search.
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+-----------------------------------------
//   in       | in_valid / in_ready            | in_req_type, in_data_byte, in_amount
//   out      | out_valid / out_ready          | out_data_out, out_valid_res, out_position,
//            |                                | out_fill_level, out_drop_total, out_last
//   cfg      | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Write, drop, clear, peek and unused codes are accepted, then load the result register.
// A read of n bytes returns one byte per cycle from the single memory read port while the
// result register is free to take it. A find walks the held bytes through that same port,
// one byte per cycle.
// Reset clears pointers, drop counter and header registers; the byte store itself is not
// cleared and needs no clearing pass. A result waits in the output register while the next
// request is accepted; a stalled output holds the sequencer at its next result.
module byte_ring_fifo_peek_find #(
  parameter int DEPTH      = 256,
  parameter int MAX_BURST  = 16,
  parameter int MAX_HEADER = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  input  logic [7:0]  in_amount,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_data_out,
  output logic        out_valid_res,
  output logic [7:0]  out_position,
  output logic [7:0]  out_fill_level,
  output logic [15:0] out_drop_total,
  output logic        out_last,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(DEPTH);
  // wide enough for amount, held count and pointer + offset before wrap
  localparam int CW = ((PW > 8) ? PW : 8) + 2;
  localparam int BW = $clog2(MAX_BURST + 1);
  localparam int HW = (MAX_HEADER < brf_pkg::HDR_LIMIT) ? MAX_HEADER : brf_pkg::HDR_LIMIT;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] BURST_C = CW'(MAX_BURST);
  localparam logic [CW-1:0] MAXH_C  = CW'(MAX_HEADER);

  // byte store
  logic [7:0] store_mem [DEPTH];
  logic [7:0] rdata_r;
  logic          rd_en, wr_en;
  logic [PW-1:0] rd_addr;

  // control state
  brf_pkg::brf_state_t state_r, state_nxt;
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [15:0]   drop_r, drop_nxt;
  logic [31:0]   pat_r, pat_nxt;
  logic [2:0]    hlen_r, hlen_nxt;
  logic          res_valid_r, res_valid_nxt;
  logic [7:0]    res_pos_r, res_pos_nxt;
  logic [7:0]    fill_r, fill_nxt;
  logic [BW-1:0] cnt_r, cnt_nxt;
  logic          pop_r, pop_nxt;
  // search walker
  logic [PW-1:0] fa_r, fa_nxt, frem_r, frem_nxt, fk_r, fk_nxt;
  logic          fvld_r, fvld_nxt;
  logic [7:0]    win_r [HW];
  logic [7:0]    win_nxt [HW];
  logic [7:0]    nwin [HW];
  // result register
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;
  logic          out_vres_r, out_vres_nxt;
  logic [7:0]    out_pos_r, out_pos_nxt;
  logic [7:0]    out_fill_r, out_fill_nxt;
  logic [15:0]   out_drop_r, out_drop_nxt;
  logic          out_last_r, out_last_nxt;

  logic          accept, slot_free, cfg_we, full, peek_ok, hlen_bad;
  logic          fmatch, fhit;
  logic [CW-1:0] held_w, amt_w, want_w, nrd_w, ndrop_w, fill_rd_w, fpos_w;
  logic [PW-1:0] fk_new;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // advance by an offset known to stay below DEPTH
  function automatic logic [PW-1:0] ptr_add(input logic [PW-1:0] p, input logic [CW-1:0] n);
    logic [CW-1:0] s;
    s = CW'(p) + n;
    if (s >= DEPTH_C) begin
      s = s - DEPTH_C;
    end
    ptr_add = s[PW-1:0];
  endfunction

  assign in_ready  = (state_r == brf_pkg::ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign pready    = 1'b1;
  assign cfg_we    = psel && penable && pwrite;
  assign prdata    = (paddr[2] == brf_pkg::REG_LEN) ? {29'd0, hlen_r} : pat_r;

  // occupancy and request sizing
  assign held_w    = (wp_r >= rp_r) ? (CW'(wp_r) - CW'(rp_r))
                                    : (CW'(wp_r) + DEPTH_C - CW'(rp_r));
  assign full      = (ptr_inc(wp_r) == rp_r);
  assign amt_w     = CW'(in_amount);
  assign want_w    = (amt_w < BURST_C) ? amt_w : BURST_C;
  assign nrd_w     = (want_w < held_w) ? want_w : held_w;
  assign ndrop_w   = (amt_w < held_w) ? amt_w : held_w;
  assign fill_rd_w = held_w - nrd_w;
  assign peek_ok   = (amt_w < held_w);
  assign hlen_bad  = (hlen_r == 3'd0) || (CW'(hlen_r) > CW'(brf_pkg::HDR_LIMIT)) ||
                     (CW'(hlen_r) > MAXH_C) || (CW'(hlen_r) > held_w);

  // header match on the window including the byte just read
  always_comb begin
    nwin[0] = rdata_r;
    for (int m = 1; m < HW; m++) begin
      nwin[m] = win_r[m-1];
    end
    fmatch = 1'b1;
    for (int j = 0; j < HW; j++) begin
      for (int m = 0; m < HW; m++) begin
        if ((j < int'(hlen_r)) && (m + j + 1 == int'(hlen_r)) &&
            (nwin[m] != pat_r[8*j +: 8])) begin
          fmatch = 1'b0;
        end
      end
    end
  end

  assign fk_new = fk_r + 1'b1;
  assign fhit   = fvld_r && fmatch && (CW'(fk_new) >= CW'(hlen_r));
  assign fpos_w = CW'(fk_new) - CW'(hlen_r);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    drop_nxt      = drop_r;
    pat_nxt       = pat_r;
    hlen_nxt      = hlen_r;
    res_valid_nxt = res_valid_r;
    res_pos_nxt   = res_pos_r;
    fill_nxt      = fill_r;
    cnt_nxt       = cnt_r;
    pop_nxt       = pop_r;
    fa_nxt        = fa_r;
    frem_nxt      = frem_r;
    fk_nxt        = fk_r;
    fvld_nxt      = 1'b0;
    win_nxt       = win_r;
    rd_en         = 1'b0;
    rd_addr       = rp_r;
    wr_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    out_vres_nxt  = out_vres_r;
    out_pos_nxt   = out_pos_r;
    out_fill_nxt  = out_fill_r;
    out_drop_nxt  = out_drop_r;
    out_last_nxt  = out_last_r;

    if (cfg_we) begin
      if (paddr[2] == brf_pkg::REG_LEN) begin
        hlen_nxt = pwdata[2:0];
      end else begin
        pat_nxt = pwdata;
      end
    end

    unique case (state_r)
      brf_pkg::ST_IDLE: begin
        if (accept) begin
          res_valid_nxt = 1'b0;
          res_pos_nxt   = 8'd0;
          state_nxt     = brf_pkg::ST_RESP;
          unique case (in_req_type)
            brf_pkg::REQ_WRITE: begin
              if (full) begin
                if (drop_r != 16'hFFFF) begin
                  drop_nxt = drop_r + 1'b1;
                end
              end else begin
                wr_en  = 1'b1;
                wp_nxt = ptr_inc(wp_r);
              end
            end
            brf_pkg::REQ_READ: begin
              if (nrd_w != '0) begin
                // issue the first pop now
                rd_en     = 1'b1;
                rd_addr   = rp_r;
                rp_nxt    = ptr_inc(rp_r);
                cnt_nxt   = nrd_w[BW-1:0];
                pop_nxt   = 1'b1;
                fill_nxt  = fill_rd_w[7:0];
                state_nxt = brf_pkg::ST_RDW;
              end
            end
            brf_pkg::REQ_PEEK: begin
              if (peek_ok) begin
                rd_en     = 1'b1;
                rd_addr   = ptr_add(rp_r, amt_w);
                cnt_nxt   = BW'(1);
                pop_nxt   = 1'b0;
                fill_nxt  = held_w[7:0];
                state_nxt = brf_pkg::ST_RDW;
              end
            end
            brf_pkg::REQ_DROP: begin
              rp_nxt = ptr_add(rp_r, ndrop_w);
            end
            brf_pkg::REQ_FIND: begin
              if (!hlen_bad) begin
                fa_nxt    = rp_r;
                frem_nxt  = held_w[PW-1:0];
                fk_nxt    = '0;
                state_nxt = brf_pkg::ST_FIND;
              end
            end
            brf_pkg::REQ_CLEAR: begin
              wp_nxt   = '0;
              rp_nxt   = '0;
              drop_nxt = 16'd0;
            end
            default: begin
            end
          endcase
        end
      end

      brf_pkg::ST_FIND: begin
        if (fvld_r) begin
          win_nxt = nwin;
          fk_nxt  = fk_new;
        end
        if (fhit) begin
          res_valid_nxt = 1'b1;
          res_pos_nxt   = fpos_w[7:0];
          state_nxt     = brf_pkg::ST_RESP;
        end else if (frem_r != '0) begin
          // fetch the next held byte
          rd_en    = 1'b1;
          rd_addr  = fa_r;
          fa_nxt   = ptr_inc(fa_r);
          frem_nxt = frem_r - 1'b1;
          fvld_nxt = 1'b1;
        end else if (!fvld_r) begin
          state_nxt = brf_pkg::ST_RESP;
        end
      end

      brf_pkg::ST_RDW: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rdata_r;
          out_vres_nxt  = 1'b1;
          out_pos_nxt   = 8'd0;
          out_fill_nxt  = fill_r;
          out_drop_nxt  = drop_r;
          out_last_nxt  = (cnt_r == BW'(1));
          if (pop_r && (cnt_r != BW'(1))) begin
            rd_en   = 1'b1;
            rd_addr = rp_r;
            rp_nxt  = ptr_inc(rp_r);
            cnt_nxt = cnt_r - 1'b1;
          end else begin
            state_nxt = brf_pkg::ST_IDLE;
          end
        end
      end

      brf_pkg::ST_RESP: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = 8'd0;
          out_vres_nxt  = res_valid_r;
          out_pos_nxt   = res_pos_r;
          out_fill_nxt  = held_w[7:0];
          out_drop_nxt  = drop_r;
          out_last_nxt  = 1'b1;
          state_nxt     = brf_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = brf_pkg::ST_IDLE;
      end
    endcase
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wp_r] <= in_data_byte;
    end
    if (rd_en) begin
      rdata_r <= store_mem[rd_addr];
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= brf_pkg::ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      drop_r      <= 16'd0;
      pat_r       <= 32'd0;
      hlen_r      <= 3'd0;
      fvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      drop_r      <= drop_nxt;
      pat_r       <= pat_nxt;
      hlen_r      <= hlen_nxt;
      fvld_r      <= fvld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res_valid_r <= res_valid_nxt;
    res_pos_r   <= res_pos_nxt;
    fill_r      <= fill_nxt;
    cnt_r       <= cnt_nxt;
    pop_r       <= pop_nxt;
    fa_r        <= fa_nxt;
    frem_r      <= frem_nxt;
    fk_r        <= fk_nxt;
    win_r       <= win_nxt;
    out_data_r  <= out_data_nxt;
    out_vres_r  <= out_vres_nxt;
    out_pos_r   <= out_pos_nxt;
    out_fill_r  <= out_fill_nxt;
    out_drop_r  <= out_drop_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_out   = out_data_r;
  assign out_valid_res  = out_vres_r;
  assign out_position   = out_pos_r;
  assign out_fill_level = out_fill_r;
  assign out_drop_total = out_drop_r;
  assign out_last       = out_last_r;

endmodule

FILE: test/tb_byte_ring_fifo_peek_find.sv
// Self-checking testbench for the byte ring FIFO with peek, drop, clear and header search.
`timescale 1ns / 100ps

typedef struct packed {
  logic [7:0]  data_out;
  logic        valid_res;
  logic [7:0]  position;
  logic [7:0]  fill_level;
  logic [15:0] drop_total;
  logic        last;
} ring_result_t;

// Tracks ring contents, pointers, drop counter and header registers, and keeps the
// results still owed by the block in order.
class byte_ring_tracker;
  localparam int BURST_CAP = 16;

  logic [7:0]   ring [256];
  logic [7:0]   wr_ptr;
  logic [7:0]   rd_ptr;
  logic [15:0]  drops;
  logic [31:0]  hdr_pattern;
  logic [2:0]   hdr_len;
  ring_result_t owed[$];
  int           errors;

  function new();
    wr_ptr = '0;
    rd_ptr = '0;
    drops = '0;
    hdr_pattern = '0;
    hdr_len = '0;
    errors = 0;
  endfunction

  function logic [7:0] held();
    return wr_ptr - rd_ptr;
  endfunction

  function void flag(string msg);
    if (errors < 10) $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endfunction

  function string show(ring_result_t r);
    return $sformatf("data %02h valid %b pos %0d fill %0d drops %0d last %b",
                     r.data_out, r.valid_res, r.position, r.fill_level, r.drop_total, r.last);
  endfunction

  function void owe(logic [7:0] d, logic v, logic [7:0] p, logic l);
    ring_result_t r;
    r.data_out = d;
    r.valid_res = v;
    r.position = p;
    r.fill_level = held();
    r.drop_total = drops;
    r.last = l;
    owed.push_back(r);
  endfunction

  function void set_reg(logic idx, logic [31:0] value);
    if (idx == brf_pkg::REG_PATTERN) hdr_pattern = value;
    else hdr_len = value[2:0];
  endfunction

  function void take_request(logic [2:0] req, logic [7:0] data, logic [7:0] amt);
    logic [7:0] got [BURST_CAP];
    logic [7:0] lvl;
    logic [7:0] pos;
    logic       hit;
    int         want, n, i, j;
    lvl = held();
    case (req)
      brf_pkg::REQ_WRITE: begin
        // full ring: drop the new byte and count it, saturating
        if (wr_ptr + 8'd1 == rd_ptr) begin
          if (drops != 16'hFFFF) drops++;
        end else begin
          ring[wr_ptr] = data;
          wr_ptr++;
        end
        owe('0, 1'b0, '0, 1'b1);
      end
      brf_pkg::REQ_READ: begin
        want = (amt < BURST_CAP) ? amt : BURST_CAP;
        n = 0;
        while (n < want && rd_ptr != wr_ptr) begin
          got[n] = ring[rd_ptr];
          rd_ptr++;
          n++;
        end
        // fill level on every byte is the level after the whole burst
        if (n == 0) owe('0, 1'b0, '0, 1'b1);
        else for (i = 0; i < n; i++) owe(got[i], 1'b1, '0, i == n - 1);
      end
      brf_pkg::REQ_PEEK: begin
        if (amt < lvl) owe(ring[8'(rd_ptr + amt)], 1'b1, '0, 1'b1);
        else owe('0, 1'b0, '0, 1'b1);
      end
      brf_pkg::REQ_DROP: begin
        rd_ptr = rd_ptr + ((amt > lvl) ? lvl : amt);
        owe('0, 1'b0, '0, 1'b1);
      end
      brf_pkg::REQ_FIND: begin
        hit = 1'b0;
        pos = '0;
        if (hdr_len != 0 && hdr_len <= brf_pkg::HDR_LIMIT && hdr_len <= lvl) begin
          for (i = 0; i + hdr_len <= lvl; i++) begin
            for (j = 0; j < hdr_len; j++)
              if (ring[8'(rd_ptr + i + j)] != hdr_pattern[8*j +: 8]) break;
            if (j == hdr_len) begin
              hit = 1'b1;
              pos = 8'(i);
              break;
            end
          end
        end
        owe('0, hit, pos, 1'b1);
      end
      brf_pkg::REQ_CLEAR: begin
        wr_ptr = '0;
        rd_ptr = '0;
        drops = '0;
        owe('0, 1'b0, '0, 1'b1);
      end
      default: owe('0, 1'b0, '0, 1'b1);
    endcase
  endfunction

  function void match_result(ring_result_t seen);
    ring_result_t due;
    if (owed.size() == 0) begin
      flag({"unexpected result: ", show(seen)});
      return;
    end
    due = owed.pop_front();
    if (seen.data_out !== due.data_out || seen.valid_res !== due.valid_res ||
        seen.position !== due.position || seen.fill_level !== due.fill_level ||
        seen.drop_total !== due.drop_total || seen.last !== due.last)
      flag({"expected ", show(due), " got ", show(seen)});
  endfunction
endclass

module tb_byte_ring_fifo_peek_find;

  // Selector codes the block must treat as no-ops
  localparam logic [2:0] REQ_SPARE6 = 3'd6;
  localparam logic [2:0] REQ_SPARE7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_req_type = '0;
  logic [7:0]  in_data_byte = '0;
  logic [7:0]  in_amount = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_data_out;
  logic        out_valid_res;
  logic [7:0]  out_position;
  logic [7:0]  out_fill_level;
  logic [15:0] out_drop_total;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_ring_tracker sb = new();

  // When set, neither side idles: back-to-back requests, result sink always ready
  bit calm = 1'b0;
  int stall_left = 0;

  logic [31:0] phase_pattern [8];
  logic [2:0]  phase_len [8] = '{3'd1, 3'd4, 3'd2, 3'd3, 3'd4, 3'd7, 3'd0, 3'd3};

  byte_ring_fifo_peek_find dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_data_byte   (in_data_byte),
    .in_amount      (in_amount),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data_out   (out_data_out),
    .out_valid_res  (out_valid_res),
    .out_position   (out_position),
    .out_fill_level (out_fill_level),
    .out_drop_total (out_drop_total),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idle length for either side: mostly none, some short, a few long
  function automatic int pick_idle();
    int roll;
    roll = $urandom_range(99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Byte that is often one of the header bytes, to provoke partial matches
  function automatic logic [7:0] near_byte();
    int k;
    k = $urandom_range(3);
    if ($urandom_range(1) != 0) return sb.hdr_pattern[8*k +: 8];
    return 8'($urandom());
  endfunction

  // Amount: mostly small, sometimes anywhere in the byte range
  function automatic logic [7:0] pick_amount();
    if ($urandom_range(3) == 0) return 8'($urandom());
    return 8'($urandom_range(20));
  endfunction

  // Result sink: take every accepted result to the tracker, stall at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        sb.match_result('{out_data_out, out_valid_res, out_position, out_fill_level,
                          out_drop_total, out_last});
      if (stall_left != 0 && !calm) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        stall_left = calm ? 0 : pick_idle();
      end
    end
  end

  // Present one request, optionally after a gap, and hold it until accepted.
  // Called and returns on a rising edge; valid stays high between back-to-back requests.
  task automatic send_req(input logic [2:0] req, input logic [7:0] data,
                          input logic [7:0] amt);
    int gap;
    gap = calm ? 0 : pick_idle();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_data_byte <= data;
    in_amount <= amt;
    do @(posedge clk); while (!in_ready);
    sb.take_request(req, data, amt);
  endtask

  // Drop valid and wait until every owed result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
  endtask

  // Register write (setup + access), then read it back over the same port
  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, value);
    // back to setup for the read, keep the select
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    want = (idx == brf_pkg::REG_LEN) ? {29'd0, value[2:0]} : value;
    if (prdata !== want)
      sb.flag($sformatf("register %0d read back %08h, written %08h", idx, prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Random traffic: header frames with noise around them, mixed with loose requests
  task automatic run_scenes(input int budget);
    int         sent, hl, bad, k, roll;
    logic [7:0] hb;
    logic [2:0] req;
    logic [7:0] amt;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(9) < 4) begin
        hl = (sb.hdr_len >= 1 && sb.hdr_len <= 4) ? sb.hdr_len : $urandom_range(4, 1);
        // break one header byte now and then
        bad = ($urandom_range(5) == 0) ? $urandom_range(hl - 1) : -1;
        repeat ($urandom_range(3)) begin
          send_req(brf_pkg::REQ_WRITE, near_byte(), 8'($urandom()));
          sent++;
        end
        for (k = 0; k < hl; k++) begin
          hb = sb.hdr_pattern[8*k +: 8];
          send_req(brf_pkg::REQ_WRITE, (k == bad) ? ~hb : hb, 8'($urandom()));
          sent++;
        end
        repeat ($urandom_range(3)) begin
          send_req(brf_pkg::REQ_WRITE, near_byte(), 8'($urandom()));
          sent++;
        end
        send_req(brf_pkg::REQ_FIND, 8'($urandom()), 8'($urandom()));
        // consume or peek at part of what is held
        case ($urandom_range(2))
          0: send_req(brf_pkg::REQ_READ, 8'($urandom()), pick_amount());
          1: send_req(brf_pkg::REQ_DROP, 8'($urandom()), 8'($urandom_range(sb.held())));
          default: send_req(brf_pkg::REQ_PEEK, 8'($urandom()),
                            8'($urandom_range(sb.held())));
        endcase
        sent += 2;
      end else begin
        roll = $urandom_range(99);
        if (roll < 38) req = brf_pkg::REQ_WRITE;
        else if (roll < 55) req = brf_pkg::REQ_READ;
        else if (roll < 70) req = brf_pkg::REQ_PEEK;
        else if (roll < 80) req = brf_pkg::REQ_DROP;
        else if (roll < 92) req = brf_pkg::REQ_FIND;
        else if (roll < 96) req = brf_pkg::REQ_CLEAR;
        else req = roll[0] ? REQ_SPARE6 : REQ_SPARE7;
        amt = pick_amount();
        if (req == brf_pkg::REQ_PEEK && $urandom_range(1) != 0)
          amt = 8'($urandom_range(sb.held()));
        send_req(req, (req == brf_pkg::REQ_WRITE) ? near_byte() : 8'($urandom()), amt);
        // no-op selectors do not count as traffic
        if (req != REQ_SPARE6 && req != REQ_SPARE7) sent++;
      end
    end
  endtask

  initial begin
    int p;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Empty ring with the reset header settings: empty read, peek past the end,
    // search with zero header length
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd3);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd0);
    send_req(brf_pkg::REQ_FIND, 8'h00, 8'd0);

    settle();
    write_reg(brf_pkg::REG_PATTERN, 32'h0000_A55A);
    write_reg(brf_pkg::REG_LEN, {29'($urandom()), 3'd2});

    // Extreme data bytes and the header sitting at offset two
    send_req(brf_pkg::REQ_WRITE, 8'h00, 8'hFF);
    send_req(brf_pkg::REQ_WRITE, 8'hFF, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'h5A, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'hA5, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'h3C, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'hC3, 8'h00);
    // Peek first, last, one past the end, and the largest offset
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd0);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd5);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd6);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd255);
    send_req(brf_pkg::REQ_FIND, 8'h00, 8'd0);
    // Zero-count read gives one empty answer; then pop two bytes
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd0);
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd2);
    send_req(brf_pkg::REQ_FIND, 8'h00, 8'd0);
    // Drop more than held, then the unused selectors
    send_req(brf_pkg::REQ_DROP, 8'h00, 8'd255);
    send_req(REQ_SPARE6, 8'hFF, 8'hFF);
    send_req(REQ_SPARE7, 8'h00, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'h11, 8'h00);
    send_req(brf_pkg::REQ_CLEAR, 8'h00, 8'h00);
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd1);

    // Random phases over several header settings, extremes among them
    for (p = 0; p < 8; p++) phase_pattern[p] = $urandom();
    phase_pattern[3] = 32'hFFFF_FFFF;
    phase_pattern[4] = 32'h0000_0000;
    for (p = 0; p < 8; p++) begin
      settle();
      write_reg(brf_pkg::REG_PATTERN, phase_pattern[p]);
      write_reg(brf_pkg::REG_LEN, {29'($urandom()), phase_len[p]});
      calm = (p == 2);
      run_scenes(4);
    end
    calm = 1'b0;

    // Fill to full with a header near the top, overflow a few times, search near
    // the top, clamp reads, then wrap the pointers with a header after the wrap
    settle();
    write_reg(brf_pkg::REG_PATTERN, $urandom());
    write_reg(brf_pkg::REG_LEN, {29'($urandom()), 3'd4});
    while (sb.held() < 8'd248)
      send_req(brf_pkg::REQ_WRITE, 8'($urandom()), 8'($urandom()));
    for (p = 0; p < 4; p++)
      send_req(brf_pkg::REQ_WRITE, sb.hdr_pattern[8*p +: 8], 8'h00);
    while (sb.held() != 8'd255)
      send_req(brf_pkg::REQ_WRITE, 8'($urandom()), 8'($urandom()));
    repeat (3) send_req(brf_pkg::REQ_WRITE, 8'($urandom()), 8'($urandom()));
    send_req(brf_pkg::REQ_FIND, 8'h00, 8'h00);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd254);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'd255);
    repeat (4) send_req(brf_pkg::REQ_READ, 8'h00, 8'd255);
    send_req(brf_pkg::REQ_DROP, 8'h00, 8'd140);
    for (p = 0; p < 4; p++)
      send_req(brf_pkg::REQ_WRITE, sb.hdr_pattern[8*p +: 8], 8'h00);
    send_req(brf_pkg::REQ_FIND, 8'h00, 8'h00);
    repeat (3) send_req(brf_pkg::REQ_READ, 8'h00, 8'd255);
    send_req(brf_pkg::REQ_PEEK, 8'h00, 8'($urandom_range(sb.held())));

    // Read, write and clear back to back with drops on record
    calm = 1'b1;
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd3);
    send_req(brf_pkg::REQ_WRITE, 8'h77, 8'h00);
    send_req(brf_pkg::REQ_CLEAR, 8'h00, 8'h00);
    send_req(brf_pkg::REQ_WRITE, 8'h88, 8'h00);
    calm = 1'b0;
    send_req(brf_pkg::REQ_READ, 8'h00, 8'd1);

    // Drain, then leave room for any stray result to show up
    settle();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // Hard stop well beyond the slowest legal run
  initial begin
    #60_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
